### rtl/stream_checkpoint_window_defines.svh
// Assertion macros shared by the checkpoint window RTL.
// No dependencies.
`ifndef STREAM_CHECKPOINT_WINDOW_DEFINES_SVH
`define STREAM_CHECKPOINT_WINDOW_DEFINES_SVH
`define SCW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SCW_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

### rtl/scw_pkg.sv
// Shared types and constants for the checkpoint window.
// No dependencies.
package scw_pkg;
    localparam int DEPTH_DEF    = 16;
    localparam int TAG_BITS_DEF = 32;
    localparam int OFS_W        = 48;
    localparam int PID_W        = 13;
    localparam int TAG_W        = 32;
    localparam int CAP_W        = 5;

    typedef enum logic [1:0] {
        MODE_APPEND  = 2'd0,
        MODE_LOOKUP  = 2'd1,
        MODE_OBSERVE = 2'd2,
        MODE_SNAP    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_PCR      = 3'd1,
        ST_CC       = 3'd2,
        ST_NOT_INC  = 3'd3,
        ST_FULL     = 3'd4,
        ST_REGRESS  = 3'd5,
        ST_NONE     = 3'd6,
        ST_EMPTY    = 3'd7
    } t_status;

    localparam logic REG_MAX_REGRESSION = 1'b0;
    localparam logic REG_CAPACITY       = 1'b1;
endpackage

### rtl/scw_if.sv
// Valid/ready channel interfaces for the checkpoint window.
// Depends on scw_pkg.
interface scw_in_if
    import scw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [OFS_W-1:0]  position;
    logic              has_bound;
    logic              has_pcr;
    logic [OFS_W-1:0]  pcr_offset;
    logic              has_cc;
    logic [OFS_W-1:0]  cc_offset;
    logic [PID_W-1:0]  cc_pid;
    logic [TAG_W-1:0]  tag;
    modport source (output valid, mode, position, has_bound, has_pcr, pcr_offset,
                    has_cc, cc_offset, cc_pid, tag, input ready);
    modport sink (input valid, mode, position, has_bound, has_pcr, pcr_offset,
                  has_cc, cc_offset, cc_pid, tag, output ready);
endinterface

interface scw_out_if
    import scw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [OFS_W-1:0]  entry_offset;
    logic              entry_has_pcr;
    logic              entry_has_cc;
    logic [PID_W-1:0]  entry_pid;
    logic [TAG_W-1:0]  entry_tag;
    logic              last;
    logic              history_complete;
    modport source (output valid, status, entry_offset, entry_has_pcr, entry_has_cc,
                    entry_pid, entry_tag, last, history_complete, input ready);
    modport sink (input valid, status, entry_offset, entry_has_pcr, entry_has_cc,
                  entry_pid, entry_tag, last, history_complete, output ready);
endinterface

interface scw_cfg_if
    import scw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              index;
    logic [OFS_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/stream_checkpoint_window.sv
// Checkpoint window: append checks the marks and the increasing order, evicts entries
// and stores the new one; observe checks for regression, raises the mark and evicts;
// lookup walks the entries at or before the position; snapshot walks the held entries.
// Entries are read one at a time from the one-read slot memory.
// One item at a time; the next is taken once the result register empties.
// Synchronous active-low reset empties the window and restores the registers.
`include "stream_checkpoint_window_defines.svh"
module stream_checkpoint_window
    import scw_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    scw_in_if.sink   i_in,
    scw_out_if.source o_out,
    scw_cfg_if.sink  i_cfg
);
    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = OFS_W + 2 + PID_W + TAG_BITS;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_EVICT = 7'b0000100,
        S_WALK  = 7'b0001000,
        S_EMIT  = 7'b0010000,
        S_WAIT  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] r_rd;

    t_state r_state, n_state;
    logic [IW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [OFS_W-1:0] r_wm, n_wm;
    logic r_wm_vld, n_wm_vld, r_cmpl, n_cmpl;
    logic [OFS_W-1:0] r_maxreg;
    logic [CAP_W-1:0] r_cap;

    logic [1:0] r_mode;
    logic [OFS_W-1:0] r_pos;
    logic r_bound, r_pcr, r_cc;
    logic [OFS_W-1:0] r_pcr_ofs, r_cc_ofs;
    logic [PID_W-1:0] r_pid;
    logic [TAG_BITS-1:0] r_tag;

    logic [CW-1:0] r_k, n_k;
    logic r_found, n_found;
    logic [EW-1:0] r_fent, n_fent;
    logic r_started, n_started;

    logic r_ov, n_ov;
    logic [2:0] r_st, n_st;
    logic [EW-1:0] r_oent, n_oent;
    logic r_olast, n_olast, r_ohas, n_ohas;

    logic rd_en, wr_en;
    logic [IW-1:0] rd_addr, wr_addr;
    logic [EW-1:0] wr_data;

    logic [CAP_W-1:0] eff_cap;
    logic [OFS_W-1:0] legal;
    logic legal_ok, regressed, in_acc;
    logic [OFS_W-1:0] rd_ofs;

    function automatic logic [IW-1:0] slot(input logic [IW-1:0] h, input logic [CW-1:0] k);
        logic [IW:0] s;
        s = {1'b0, h} + {1'b0, k[IW-1:0]};
        if (s >= (IW+1)'(DEPTH)) s = s - (IW+1)'(DEPTH);
        return s[IW-1:0];
    endfunction

    assign in_acc = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE) && !r_ov;
    assign i_cfg.ready = 1'b1;
    assign rd_ofs = r_rd[EW-1 -: OFS_W];

    always_comb begin
        if (r_cap == '0) eff_cap = CAP_W'(1);
        else if (32'(r_cap) > DEPTH) eff_cap = CAP_W'(DEPTH);
        else eff_cap = r_cap;
    end

    assign legal_ok = r_wm_vld && (r_wm > r_maxreg);
    assign legal = r_wm - r_maxreg;
    assign regressed = r_wm_vld && (r_wm > r_pos) && ((r_wm - r_pos) > r_maxreg);

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode <= i_in.mode;
            r_pos <= i_in.position;
            r_bound <= i_in.has_bound;
            r_pcr <= i_in.has_pcr;
            r_pcr_ofs <= i_in.pcr_offset;
            r_cc <= i_in.has_cc;
            r_cc_ofs <= i_in.cc_offset;
            r_pid <= i_in.cc_pid;
            r_tag <= TAG_BITS'(i_in.tag);
        end
    end

    always_comb begin
        n_state = r_state; n_head = r_head; n_count = r_count;
        n_wm = r_wm; n_wm_vld = r_wm_vld; n_cmpl = r_cmpl;
        n_k = r_k; n_found = r_found; n_fent = r_fent; n_started = r_started;
        n_ov = r_ov; n_st = r_st; n_oent = r_oent; n_olast = r_olast; n_ohas = r_ohas;
        rd_en = 1'b0; rd_addr = slot(r_head, r_k);
        wr_en = 1'b0; wr_addr = slot(r_head, r_count);
        wr_data = {r_pos, r_cc, r_pcr, (r_cc ? r_pid : PID_W'(0)), r_tag};
        if (r_ov && o_out.ready) n_ov = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_CHECK;
                    n_k = (i_in.mode == MODE_APPEND) ? r_count - CW'(1) : '0;
                    n_found = 1'b0;
                    n_started = 1'b0;
                end
            end
            S_CHECK: begin
                rd_en = 1'b1;
                unique case (t_mode'(r_mode))
                    MODE_APPEND: begin
                        if (r_pcr && r_pcr_ofs != r_pos) begin
                            n_st = ST_PCR; n_state = S_DONE;
                        end else if (r_cc && r_cc_ofs != r_pos) begin
                            n_st = ST_CC; n_state = S_DONE;
                        end else begin
                            n_state = S_WAIT;
                        end
                    end
                    MODE_OBSERVE: begin
                        rd_addr = slot(r_head, CW'(1));
                        if (regressed) begin
                            n_st = ST_REGRESS; n_state = S_DONE;
                        end else begin
                            n_st = ST_OK;
                            if (!r_wm_vld || r_pos > r_wm) begin
                                n_wm = r_pos; n_wm_vld = 1'b1;
                                n_k = CW'(1);
                                n_state = S_EVICT;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                    end
                    MODE_LOOKUP: begin
                        if (regressed) begin
                            n_st = ST_REGRESS; n_state = S_DONE;
                        end else begin
                            n_state = S_WALK;
                            n_k = CW'(1);
                        end
                    end
                    default: begin
                        n_state = S_WALK;
                        n_k = CW'(1);
                    end
                endcase
            end
            S_WAIT: begin
                if (r_count != '0 && r_pos <= rd_ofs) begin
                    n_st = ST_NOT_INC; n_state = S_DONE;
                end else begin
                    n_k = CW'(1);
                    rd_addr = slot(r_head, CW'(1));
                    rd_en = 1'b1;
                    n_state = S_EVICT;
                end
            end
            S_EVICT: begin
                // r_rd holds the second-oldest entry when the count allows it.
                if (r_count > CW'(1) && legal_ok && rd_ofs <= legal) begin
                    n_head = slot(r_head, CW'(1));
                    n_count = r_count - CW'(1);
                    n_cmpl = 1'b0;
                    rd_addr = slot(r_head, CW'(2));
                    rd_en = 1'b1;
                end else if (r_mode == MODE_APPEND) begin
                    if (32'(r_count) >= 32'(eff_cap)) begin
                        n_st = ST_FULL;
                    end else begin
                        wr_en = 1'b1;
                        n_count = r_count + CW'(1);
                        n_st = ST_OK;
                    end
                    n_state = S_DONE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WALK: begin
                // r_rd holds entry r_k - 1.
                if (r_k > r_count) begin
                    if (r_mode == MODE_LOOKUP) begin
                        n_st = r_found ? ST_OK : ST_NONE;
                        n_state = S_DONE;
                    end else begin
                        n_state = r_started ? S_IDLE : S_DONE;
                        n_st = ST_EMPTY;
                        if (r_started) begin
                            n_ov = 1'b1; n_st = ST_OK; n_oent = r_fent;
                            n_ohas = 1'b1; n_olast = 1'b1;
                        end
                    end
                end else if (r_mode == MODE_LOOKUP) begin
                    if (rd_ofs > r_pos) begin
                        n_st = r_found ? ST_OK : ST_NONE;
                        n_state = S_DONE;
                    end else begin
                        n_found = 1'b1; n_fent = r_rd;
                        rd_en = 1'b1; n_k = r_k + CW'(1);
                    end
                end else if (!r_bound || rd_ofs > r_pos || r_started) begin
                    if (r_started) begin
                        if (!r_ov || o_out.ready) begin
                            n_ov = 1'b1; n_st = ST_OK; n_oent = r_fent;
                            n_ohas = 1'b1; n_olast = 1'b0;
                            n_fent = r_rd; rd_en = 1'b1; n_k = r_k + CW'(1);
                        end
                    end else begin
                        n_started = 1'b1; n_fent = r_rd;
                        rd_en = 1'b1; n_k = r_k + CW'(1);
                    end
                end else begin
                    rd_en = 1'b1; n_k = r_k + CW'(1);
                end
            end
            S_EMIT: n_state = S_DONE;
            S_DONE: begin
                if (!r_ov || o_out.ready) begin
                    n_ov = 1'b1; n_olast = 1'b1;
                    n_ohas = (r_mode == MODE_LOOKUP) && r_found && (r_st == ST_OK);
                    n_oent = r_fent;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_WALK && n_state == S_IDLE && r_ov && !o_out.ready) begin
            n_state = S_WALK;
            n_ov = r_ov;
            n_st = r_st; n_oent = r_oent; n_ohas = r_ohas; n_olast = r_olast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head <= '0; r_count <= '0; r_wm <= '0; r_wm_vld <= 1'b0; r_cmpl <= 1'b1;
            r_maxreg <= '0; r_cap <= CAP_W'(16);
            r_ov <= 1'b0; r_k <= '0; r_found <= 1'b0; r_started <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head <= n_head; r_count <= n_count; r_wm <= n_wm;
            r_wm_vld <= n_wm_vld; r_cmpl <= n_cmpl;
            r_ov <= n_ov; r_k <= n_k; r_found <= n_found; r_started <= n_started;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    REG_MAX_REGRESSION: r_maxreg <= i_cfg.data;
                    REG_CAPACITY:       r_cap <= i_cfg.data[CAP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_st <= n_st; r_oent <= n_oent; r_olast <= n_olast; r_ohas <= n_ohas; r_fent <= n_fent;
    end

    logic [PID_W-1:0] ent_pid;
    logic [TAG_BITS-1:0] ent_tag;
    assign ent_pid = r_oent[TAG_BITS +: PID_W];
    assign ent_tag = r_oent[TAG_BITS-1:0];

    assign o_out.valid = r_ov;
    assign o_out.status = r_st;
    assign o_out.entry_offset = r_ohas ? r_oent[EW-1 -: OFS_W] : '0;
    assign o_out.entry_has_pcr = r_ohas & r_oent[TAG_BITS + PID_W];
    assign o_out.entry_has_cc = r_ohas & r_oent[TAG_BITS + PID_W + 1];
    assign o_out.entry_pid = r_ohas ? ent_pid : '0;
    assign o_out.entry_tag = r_ohas ? TAG_W'(ent_tag) : '0;
    assign o_out.last = r_olast;
    assign o_out.history_complete = r_cmpl;

    `SCW_ASSERT(a_count_cap, i_clk, i_rst_n, 32'(r_count) <= DEPTH, "entry count exceeds depth")
    `SCW_ASSERT(a_cmpl_sticky, i_clk, i_rst_n, !r_cmpl |=> !r_cmpl, "history flag set again")
    `SCW_ASSERT_NEVER(a_wr_full, i_clk, i_rst_n, wr_en && 32'(r_count) >= DEPTH, "write to full ring")
endmodule
